/* hw/rtl/b64enc_pkg.sv */
// Shared types and constants for the base64 stream encoder.
// Holds the group descriptor passed from front to back and the alphabet map.
// No dependencies.
`timescale 1ns / 1ps

package b64enc_pkg;

  localparam int unsigned GroupW = 24;
  localparam int unsigned SextetW = 6;
  localparam int unsigned CharW = 7;
  localparam logic [CharW-1:0] PadChar = 7'd61;

  // Number of pad characters at the end of a group: 0, 1 or 2.
  typedef logic [1:0] pad_cnt_t;

  typedef struct packed {
    logic [GroupW-1:0] group;  // bytes packed high first, zero filled
    pad_cnt_t          npad;
    logic              last;   // group closes the message
  } job_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [CharW-1:0] sextet_to_ascii(input logic [SextetW-1:0] s);
    logic [CharW-1:0] s_ext;
    logic [CharW-1:0] ch;
    s_ext = {1'b0, s};
    if (s < 6'd26) begin
      ch = 7'd65 + s_ext;
    end else if (s < 6'd52) begin
      ch = 7'd71 + s_ext;
    end else if (s < 6'd62) begin
      ch = s_ext - 7'd4;
    end else if (s == 6'd62) begin
      ch = 7'd43;
    end else begin
      ch = 7'd47;
    end
    return ch;
  endfunction

endpackage

/* hw/rtl/b64enc_front.sv */
// Front end of the base64 encoder: collects bytes into three-byte groups.
// Issues one group descriptor per complete group or per closing byte. Uses b64enc_pkg.
`timescale 1ns / 1ps

module b64enc_front import b64enc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,   // [7:0] in_byte
  input  logic       s_tlast_i,   // in_last
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output job_t       push_job_o
);

  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] pend_q, pend_d;
  logic        accept;

  assign s_tready_o   = push_ready_i;
  assign accept       = s_tvalid_i & push_ready_i;
  // A group leaves on the third byte, or early when the message ends.
  assign push_valid_o = accept & (cnt_q[1] | s_tlast_i);

  always_comb begin
    push_job_o.last = s_tlast_i;
    if (cnt_q[1]) begin
      push_job_o.group = {pend_q, s_tdata_i};
      push_job_o.npad  = 2'd0;
    end else if (cnt_q[0]) begin
      push_job_o.group = {pend_q[7:0], s_tdata_i, 8'h00};
      push_job_o.npad  = 2'd1;
    end else begin
      push_job_o.group = {s_tdata_i, 16'h0000};
      push_job_o.npad  = 2'd2;
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    pend_d = pend_q;
    if (accept) begin
      if (cnt_q[1] || s_tlast_i) begin
        cnt_d  = 2'd0;
        pend_d = 16'h0000;
      end else if (cnt_q == 2'd0) begin
        cnt_d  = 2'd1;
        pend_d = {8'h00, s_tdata_i};
      end else begin
        cnt_d  = 2'd2;
        pend_d = {pend_q[7:0], s_tdata_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      pend_q <= 16'h0000;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

endmodule

/* hw/rtl/b64enc_fifo.sv */
// Two-entry queue of group descriptors between front and back end.
// Registered storage with read and write pointers. Uses b64enc_pkg.
`timescale 1ns / 1ps

module b64enc_fifo import b64enc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

/* hw/rtl/b64enc_back.sv */
// Back end of the base64 encoder: expands each group into four characters.
// One registered character per cycle unless stalled. Uses b64enc_pkg.
`timescale 1ns / 1ps

module b64enc_back import b64enc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  job_t       pop_job_i,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,   // [6:0] out_char, [7] zero
  output logic       m_tlast_o    // out_last
);

  job_t             cur_q;
  logic             cur_valid_q;
  logic [1:0]       idx_q;
  logic             out_valid_q;
  logic [CharW-1:0] out_char_q;
  logic             out_last_q;

  logic               out_load;
  logic               grp_done;
  logic               do_pop;
  logic [SextetW-1:0] sextet;
  logic [2:0]         pad_sum;
  logic               is_pad;
  logic [CharW-1:0]   char_d;

  assign out_load    = cur_valid_q & (~out_valid_q | m_tready_i);
  assign grp_done    = out_load & (idx_q == 2'd3);
  assign pop_ready_o = ~cur_valid_q | grp_done;
  assign do_pop      = pop_valid_i & pop_ready_o;

  always_comb begin
    unique case (idx_q)
      2'd0:    sextet = cur_q.group[23:18];
      2'd1:    sextet = cur_q.group[17:12];
      2'd2:    sextet = cur_q.group[11:6];
      default: sextet = cur_q.group[5:0];
    endcase
  end

  // The trailing npad positions of the group are pad characters.
  assign pad_sum = {1'b0, idx_q} + {1'b0, cur_q.npad};
  assign is_pad  = (pad_sum > 3'd3);
  assign char_d  = is_pad ? PadChar : sextet_to_ascii(sextet);

  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      cur_q <= pop_job_i;
    end
    if (out_load) begin
      out_char_q <= char_d;
      out_last_q <= cur_q.last & (idx_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_pop) begin
        cur_valid_q <= 1'b1;
        idx_q       <= 2'd0;
      end else if (out_load) begin
        cur_valid_q <= ~grp_done;
        idx_q       <= idx_q + 2'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {1'b0, out_char_q};
  assign m_tlast_o  = out_last_q;

endmodule

/* hw/rtl/base64_stream_encoder_top.sv */
// Base64 stream encoder: one byte per input word, one ASCII character per output word.
// A group's first character passes the queue, group register and output register after its
// closing byte is accepted. Input takes one byte per cycle while the queue has room. Output
// is one character per cycle unless stalled, four per group, so input sustains three bytes
// per four characters. Reset (asynchronous, active low) empties the pending bytes, the queue
// and the output register. Uses b64enc_pkg, b64enc_front, b64enc_fifo and b64enc_back.
`timescale 1ns / 1ps

module base64_stream_encoder_top import b64enc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // in_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [6:0] out_char, [7] zero
  output logic       m_axis_tlast_o    // out_last
);

  logic push_valid, push_ready;
  job_t push_job;
  logic pop_valid, pop_ready;
  job_t pop_job;

  b64enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_o   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .s_tlast_i    (s_axis_tlast_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  b64enc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tlast_o   (m_axis_tlast_o)
  );

endmodule
